// ===== rtl/utf_pkg.sv =====
package utf_pkg;

	// field widths of the transactions
	localparam int CHAN_W = 3;
	localparam int CHAR_W = 9;
	localparam int WORD_W = 14;
	localparam int FILL_W = 5;
	localparam int CFG_W  = 32;

	// default geometry
	localparam int CHANNELS_DEF    = 8;
	localparam int QUEUE_DEPTH_DEF = 16;

	// character length limits
	localparam logic [3:0] LEN_MIN = 4'd5;
	localparam logic [3:0] LEN_MAX = 4'd9;

	// register indexes
	localparam logic [1:0] CFG_CHAR_LENGTHS = 2'd0;
	localparam logic [1:0] CFG_PARITY_MODES = 2'd1;
	localparam logic [1:0] CFG_STOP_MODES   = 2'd2;

	// register reset values
	localparam logic [31:0] CHAR_LENGTHS_RST = 32'h8888_8888;
	localparam logic [23:0] PARITY_MODES_RST = 24'h00_0000;
	localparam logic [7:0]  STOP_MODES_RST   = 8'h00;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_TAKE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		PAR_NONE  = 3'd0,
		PAR_EVEN  = 3'd1,
		PAR_ODD   = 3'd2,
		PAR_MARK  = 3'd3,
		PAR_SPACE = 3'd4
	} parity_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [CHAN_W-1:0]   channel;
		logic [CHAR_W-1:0]   character;
	} in_item_t;

	typedef struct packed {
		logic                accepted;
		logic [WORD_W-1:0]   encoded_word;
		logic [FILL_W-1:0]   fill_level;
	} out_item_t;

	// request from the pipeline to the queue store
	typedef struct packed {
		logic step;
		logic take;
		logic ch_ok;
	} q_req_t;

endpackage

// ===== rtl/utf_framer.sv =====
module utf_framer
	import utf_pkg::*;
(
	input  logic [CHAR_W-1:0] character,
	input  logic [3:0]        len_raw,
	input  logic [2:0]        pmode,
	input  logic              two_stop,
	output logic [WORD_W-1:0] word
);

	logic [3:0]        len;
	logic [CHAR_W-1:0] mask;
	logic [CHAR_W-1:0] data;
	logic [CHAR_W-1:0] rev9;
	logic [CHAR_W-1:0] rev;
	logic              par;
	logic              has_par;
	logic              par_bit;
	logic [3:0]        pos_par;
	logic [3:0]        pos_stop;
	logic [WORD_W-1:0] frame;

	// clamp length to the legal range
	always_comb begin
		if (len_raw < LEN_MIN) begin
			len = LEN_MIN;
		end else if (len_raw > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = len_raw;
		end
	end

	// mask, reverse and parity of the data bits
	always_comb begin
		mask = CHAR_W'((10'd1 << len) - 10'd1);
		data = character & mask;
		for (int i = 0; i < CHAR_W; i++) begin
			rev9[i] = data[CHAR_W-1-i];
		end
		rev = rev9 >> (4'(CHAR_W) - len);
		par = ^data;
	end

	// parity bit selection
	always_comb begin
		has_par = 1'b1;
		par_bit = 1'b0;
		unique case (pmode)
			PAR_EVEN:  par_bit = par;
			PAR_ODD:   par_bit = ~par;
			PAR_MARK:  par_bit = 1'b1;
			PAR_SPACE: par_bit = 1'b0;
			default:   has_par = 1'b0;
		endcase
	end

	// frame assembly: start, data, optional parity, stop bits, then transition code
	always_comb begin
		pos_par  = len + 4'd1;
		pos_stop = pos_par + {3'd0, has_par};
		frame    = {{(WORD_W-CHAR_W-1){1'b0}}, rev, 1'b1};
		if (has_par) begin
			frame = frame | (WORD_W'(par_bit) << pos_par);
		end
		frame = frame | (WORD_W'(two_stop ? 2'b11 : 2'b01) << pos_stop);
		word  = ((frame << 1) | WORD_W'(1)) ^ frame;
	end

endmodule

// ===== rtl/utf_queue.sv =====
module utf_queue
	import utf_pkg::*;
#(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q_req_t            req,
	input  logic [CHAN_W-1:0] channel,
	input  logic [WORD_W-1:0] wr_word,
	output logic              accepted,
	output logic [FILL_W-1:0] fill_level,
	output logic [WORD_W-1:0] rd_word_q
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT   = CHANNELS * QUEUE_DEPTH;
	localparam int AW    = (ENT > 1) ? $clog2(ENT) : 1;

	logic [CW-1:0]     count_q [CHANNELS];
	logic [PW-1:0]     wr_ptr_q [CHANNELS];
	logic [PW-1:0]     rd_ptr_q [CHANNELS];
	logic [WORD_W-1:0] mem [ENT];

	logic [CH_W-1:0] ch_idx;
	logic [CW-1:0]   count;
	logic [PW-1:0]   wr_ptr;
	logic [PW-1:0]   rd_ptr;
	logic            do_put;
	logic            do_take;
	logic [CW-1:0]   count_nxt;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;

	// look up the channel's queue state
	always_comb begin
		ch_idx    = CH_W'(channel);
		count     = count_q[ch_idx];
		wr_ptr    = wr_ptr_q[ch_idx];
		rd_ptr    = rd_ptr_q[ch_idx];
		do_put    = req.ch_ok && !req.take && (count < CW'(QUEUE_DEPTH));
		do_take   = req.ch_ok && req.take && (count != '0);
		count_nxt = count;
		if (do_put) begin
			count_nxt = count + 1'b1;
		end else if (do_take) begin
			count_nxt = count - 1'b1;
		end
		accepted   = do_put || do_take;
		fill_level = req.ch_ok ? FILL_W'(count_nxt) : '0;
		waddr      = AW'(ch_idx) * AW'(QUEUE_DEPTH) + AW'(wr_ptr);
		raddr      = AW'(ch_idx) * AW'(QUEUE_DEPTH) + AW'(rd_ptr);
	end

	// per-channel counts and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				count_q[c]  <= '0;
				wr_ptr_q[c] <= '0;
				rd_ptr_q[c] <= '0;
			end
		end else if (req.step) begin
			count_q[ch_idx] <= count_nxt;
			if (do_put) begin
				wr_ptr_q[ch_idx] <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q[ch_idx] <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
			end
		end
	end

	// word store, registered read
	always_ff @(posedge clk) begin
		if (req.step && do_put) begin
			mem[waddr] <= wr_word;
		end
		if (req.step && do_take) begin
			rd_word_q <= mem[raddr];
		end
	end

endmodule

// ===== rtl/uart_tx_frame_queue_core.sv =====
// an accepted transaction passes through the input register and then the result register
// throughput: one transaction per cycle while out_ready does not hold back a result, set by the single queue store port
// the input register takes one more transaction while a result waits, then input stalls
// reset: asynchronous, active low; queues empty, registers at their defaults
module uart_tx_frame_queue_core
	import utf_pkg::*;
#(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [31:0] char_lengths_q;
	logic [23:0] parity_modes_q;
	logic [7:0]  stop_modes_q;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	logic      acc_s2;
	logic      take_s2;
	logic [WORD_W-1:0] word_s2;
	logic [FILL_W-1:0] fill_s2;

	logic      adv_s2;
	logic      step;
	logic      ch_ok;
	q_req_t    req;
	logic [WORD_W-1:0] built_word;
	logic      q_accepted;
	logic [FILL_W-1:0] q_fill;
	logic [WORD_W-1:0] rd_word_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_lengths_q <= CHAR_LENGTHS_RST;
			parity_modes_q <= PARITY_MODES_RST;
			stop_modes_q   <= STOP_MODES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHAR_LENGTHS: char_lengths_q <= cfg_data[31:0];
				CFG_PARITY_MODES: parity_modes_q <= cfg_data[23:0];
				CFG_STOP_MODES:   stop_modes_q   <= cfg_data[7:0];
				default:          ;
			endcase
		end
	end

	// pipeline flow control
	assign adv_s2   = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;
	assign ch_ok    = 32'(item_s1.channel) < CHANNELS;

	always_comb begin
		req.step  = step;
		req.take  = (item_s1.opcode == OP_TAKE);
		req.ch_ok = ch_ok;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// frame builder
	utf_framer u_framer (
		.character (item_s1.character),
		.len_raw   (char_lengths_q[4*item_s1.channel +: 4]),
		.pmode     (parity_modes_q[3*item_s1.channel +: 3]),
		.two_stop  (stop_modes_q[item_s1.channel]),
		.word      (built_word)
	);

	// per-channel queues
	utf_queue #(
		.CHANNELS    (CHANNELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.channel    (item_s1.channel),
		.wr_word    (built_word),
		.accepted   (q_accepted),
		.fill_level (q_fill),
		.rd_word_q  (rd_word_q)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			acc_s2  <= q_accepted;
			take_s2 <= q_accepted && req.take;
			word_s2 <= (q_accepted && !req.take) ? built_word : '0;
			fill_s2 <= q_fill;
		end
	end

	// result transaction
	assign out_valid             = valid_s2;
	assign out_item.accepted     = acc_s2;
	assign out_item.encoded_word = take_s2 ? rd_word_q : word_s2;
	assign out_item.fill_level   = fill_s2;

	// checks
	a_reject_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.accepted |-> out_item.encoded_word == '0)
		else $error("rejected transaction carries a nonzero word");

	a_word_lsb_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.accepted |-> !out_item.encoded_word[0])
		else $error("encoded word has bit 0 set");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_item.fill_level) <= QUEUE_DEPTH)
		else $error("fill level above queue depth");

	a_stall_only_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

endmodule

// ===== tb/uart_tx_frame_queue_core_tb.sv =====
module uart_tx_frame_queue_core_tb;
	import utf_pkg::*;

	localparam int         NUM_CH     = CHANNELS_DEF;
	localparam int         DEPTH      = QUEUE_DEPTH_DEF;
	localparam int         PHASES     = 6;
	localparam int         PHASE_LEN  = 310;
	localparam int         MAX_CYCLES = 400000;
	localparam int         MAX_GAP    = 11;
	localparam int         LONG_HOLD  = 300;
	// index past the end of the register list, writes to it are dropped
	localparam logic [1:0] CFG_SPARE  = 2'd3;

	// mirror of the per-channel framer and word queues
	class frame_queue_scoreboard;
		logic [31:0]       char_lens;
		logic [23:0]       par_modes;
		logic [7:0]        two_stop_mask;
		logic [WORD_W-1:0] slot [NUM_CH*DEPTH];
		int                wr_pos [NUM_CH];
		int                rd_pos [NUM_CH];
		int                count [NUM_CH];
		out_item_t         pending_results [$];
		int                mismatches;
		int                checked;
		int                puts_stored;
		int                puts_full;
		int                takes_found;
		int                takes_empty;
		int                reg_writes;

		function new();
			char_lens = CHAR_LENGTHS_RST;
			par_modes = PARITY_MODES_RST;
			two_stop_mask = STOP_MODES_RST;
			foreach (slot[i]) slot[i] = '0;
			foreach (count[i]) begin
				wr_pos[i] = 0;
				rd_pos[i] = 0;
				count[i] = 0;
			end
			mismatches = 0;
			checked = 0;
			puts_stored = 0;
			puts_full = 0;
			takes_found = 0;
			takes_empty = 0;
			reg_writes = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
			reg_writes++;
			case (idx)
				CFG_CHAR_LENGTHS: char_lens = data;
				CFG_PARITY_MODES: par_modes = data[23:0];
				CFG_STOP_MODES:   two_stop_mask = data[7:0];
				default: ;
			endcase
		endfunction

		// start, reversed data, optional parity, stop bits, then transition code
		function logic [WORD_W-1:0] frame_word(int ch, logic [CHAR_W-1:0] chr);
			logic [3:0]  len;
			logic [2:0]  pm;
			logic [15:0] frame;
			logic [15:0] coded;
			logic        par;
			int          pos;
			len = char_lens[4*ch +: 4];
			if (len < LEN_MIN) len = LEN_MIN;
			if (len > LEN_MAX) len = LEN_MAX;
			pm = par_modes[3*ch +: 3];
			frame = 16'd1;
			par = 1'b0;
			for (int i = 0; i < int'(len); i++) begin
				frame[int'(len) - i] = chr[i];
				par ^= chr[i];
			end
			pos = 1 + int'(len);
			case (pm)
				PAR_EVEN:  begin frame[pos] = par;  pos++; end
				PAR_ODD:   begin frame[pos] = ~par; pos++; end
				PAR_MARK:  begin frame[pos] = 1'b1; pos++; end
				PAR_SPACE: begin frame[pos] = 1'b0; pos++; end
				default: ;
			endcase
			frame[pos] = 1'b1;
			pos++;
			if (two_stop_mask[ch]) frame[pos] = 1'b1;
			coded = ((frame << 1) | 16'd1) ^ frame;
			return coded[WORD_W-1:0];
		endfunction

		// accepted input transaction: update queues, queue up the expected result
		function void note_input(in_item_t it);
			out_item_t r;
			int        ch;
			ch = it.channel;
			r = '0;
			if (it.opcode == OP_PUT) begin
				if (count[ch] < DEPTH) begin
					r.encoded_word = frame_word(ch, it.character);
					slot[ch*DEPTH + wr_pos[ch]] = r.encoded_word;
					wr_pos[ch] = (wr_pos[ch] + 1) % DEPTH;
					count[ch]++;
					r.accepted = 1'b1;
					puts_stored++;
				end else begin
					puts_full++;
				end
			end else begin
				if (count[ch] > 0) begin
					r.encoded_word = slot[ch*DEPTH + rd_pos[ch]];
					rd_pos[ch] = (rd_pos[ch] + 1) % DEPTH;
					count[ch]--;
					r.accepted = 1'b1;
					takes_found++;
				end else begin
					takes_empty++;
				end
			end
			r.fill_level = FILL_W'(count[ch]);
			pending_results.push_back(r);
		endfunction

		// accepted output transaction against the oldest expectation
		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: acc=%0b word=%h fill=%0d",
						got.accepted, got.encoded_word, got.fill_level);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.accepted !== want.accepted || got.encoded_word !== want.encoded_word ||
					got.fill_level !== want.fill_level) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: want acc=%0b word=%h fill=%0d, got acc=%0b word=%h fill=%0d",
						checked, want.accepted, want.encoded_word, want.fill_level,
						got.accepted, got.encoded_word, got.fill_level);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_item_t         in_item = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_item;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	frame_queue_scoreboard sb;
	int                    cycles = 0;
	bit                    tx_idle = 1'b1;
	bit                    rx_idle = 1'b1;
	int                    rx_hold = 0;
	int                    put_pct;
	int                    span;
	int                    base_ch;

	uart_tx_frame_queue_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// transaction monitor and cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_input(in_item);
			if (out_valid && out_ready) sb.check_result(out_item);
		end
	end

	// receiver: random stall before each result, one long hold when asked
	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// offer one input transaction after a random gap, return once accepted
	task automatic send_item(opcode_t op, int ch, logic [CHAR_W-1:0] chr);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item.opcode <= op;
		in_item.channel <= ch[CHAN_W-1:0];
		in_item.character <= chr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// wait on the clock first so the monitor has noted the last accepted transaction
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic send_random();
		opcode_t op;
		op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_TAKE;
		send_item(op, (base_ch + $urandom_range(0, span - 1)) % NUM_CH,
			CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1)));
	endtask

	// stimulus
	initial begin
		logic [23:0] pm;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lengths below, inside and above the legal range, every parity code,
		// mixed stop bits, and a write to the unused index
		cfg_write(CFG_CHAR_LENGTHS, 32'hF987_6540);
		cfg_write(CFG_PARITY_MODES, {8'h00, 24'o76543210});
		cfg_write(CFG_STOP_MODES, 32'h0000_00AA);
		cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
		cfg_we <= 1'b0;

		// directed: empty take, all-ones and all-zero characters, odd patterns
		send_item(OP_TAKE, 0, '0);
		for (int ch = 0; ch < NUM_CH; ch++) send_item(OP_PUT, ch, 9'h1FF);
		for (int ch = 0; ch < NUM_CH; ch++) send_item(OP_PUT, ch, 9'h000);
		send_item(OP_PUT, 1, 9'h0AA);
		send_item(OP_PUT, 2, 9'h0FF);
		send_item(OP_PUT, 5, 9'h155);
		send_item(OP_TAKE, 0, 9'h1FF);
		send_item(OP_TAKE, 0, 9'h1FF);
		send_item(OP_TAKE, 0, '0);
		send_item(OP_TAKE, 7, '0);
		drain();

		// random phases, each with its own register setting and traffic mix
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			repeat (3) @(posedge clk);
			case (ph)
				0: begin
					cfg_write(CFG_CHAR_LENGTHS, CHAR_LENGTHS_RST);
					cfg_write(CFG_PARITY_MODES, {8'h00, PARITY_MODES_RST});
					cfg_write(CFG_STOP_MODES, {24'h0, STOP_MODES_RST});
				end
				1: begin
					cfg_write(CFG_CHAR_LENGTHS, '0);
					cfg_write(CFG_PARITY_MODES, '0);
					cfg_write(CFG_STOP_MODES, '0);
					cfg_write(CFG_SPARE, $urandom());
				end
				2: begin
					cfg_write(CFG_CHAR_LENGTHS, 32'hFFFF_FFFF);
					cfg_write(CFG_PARITY_MODES, 32'h00FF_FFFF);
					cfg_write(CFG_STOP_MODES, 32'h0000_00FF);
				end
				default: begin
					for (int ch = 0; ch < NUM_CH; ch++)
						pm[3*ch +: 3] = 3'($urandom_range(0, 7));
					cfg_write(CFG_CHAR_LENGTHS, $urandom());
					cfg_write(CFG_PARITY_MODES, {8'h00, pm});
					cfg_write(CFG_STOP_MODES, CFG_W'($urandom_range(0, 255)));
				end
			endcase
			cfg_we <= 1'b0;

			case (ph)
				0: begin put_pct = 60; span = 8; end
				1: begin put_pct = 75; span = 2; end
				2: begin put_pct = 40; span = 8; end
				3: begin put_pct = 55; span = 8; end
				4: begin put_pct = 85; span = 1; end
				default: begin put_pct = 25; span = 8; end
			endcase
			base_ch = $urandom_range(0, NUM_CH - 1);

			for (int i = 0; i < PHASE_LEN; i++) begin
				// back-to-back traffic in one phase, random gaps elsewhere
				if (ph == 2) begin
					tx_idle = 1'b0;
					rx_idle = 1'b0;
				end else if (i % 60 == 0) begin
					tx_idle = ($urandom_range(0, 2) != 0);
					rx_idle = ($urandom_range(0, 2) != 0);
				end
				// long receiver hold while the sender keeps pushing
				if (ph == 2 && i == 100) rx_hold = LONG_HOLD;
				// sender pause until the block has emptied
				if (ph == 3 && i == 150) drain();
				send_random();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("checked %0d results over %0d register writes, %0d random phases",
			sb.checked, sb.reg_writes, PHASES);
		$display("puts stored %0d, puts to a full queue %0d, takes %0d, empty takes %0d",
			sb.puts_stored, sb.puts_full, sb.takes_found, sb.takes_empty);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
